@@ hdl/sharpen_3x3_convolution_defines.svh @@
// Assertion macros shared by the sharpen filter modules.
`ifndef SHARPEN_3X3_CONVOLUTION_DEFINES_SVH
`define SHARPEN_3X3_CONVOLUTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that cons follows whenever ante holds, in the same cycle.
`define SH3_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("sh3 assertion failed");
// Check that cons holds in the cycle after ante.
`define SH3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("sh3 assertion failed");
`else
`define SH3_ASSERT_IMPLIES(lbl, ante, cons)
`define SH3_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hdl/sh3_pkg.sv @@
// Types, constants and arithmetic helpers of the 3x3 sharpen filter.
package sh3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int CNT_W   = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);
  localparam int ROW_W   = CNT_W - 1;
  localparam int STEP_W  = $clog2(CNT_W);

  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 13'd480;

  localparam int OUT_DEPTH = 4;
  localparam int OPTR_W    = $clog2(OUT_DEPTH);
  localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_word_t;

  localparam int LINE_W = $bits(line_word_t);

  typedef struct packed {
    pixel_t center;
    pixel_t up;
    pixel_t down;
    pixel_t left;
    pixel_t right;
  } taps_t;

  typedef struct packed {
    pixel_t px;
    logic   frame_end;
  } result_t;

  typedef struct packed {
    logic             load;
    logic [COL_W-1:0] ocol;
    logic [ROW_W-1:0] orow;
  } pos_load_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_THR,
    SEQ_DIV,
    SEQ_LOAD
  } seq_state_t;

  function automatic logic [CFG_W_W-1:0] clamp_width(logic [CFG_W_W-1:0] v);
    logic [CFG_W_W-1:0] res;
    if (v < CFG_W_W'(3)) begin
      res = CFG_W_W'(3);
    end else if (v > CFG_W_W'(MAX_WIDTH)) begin
      res = CFG_W_W'(MAX_WIDTH);
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [CFG_H_W-1:0] clamp_height(logic [CFG_H_W-1:0] v);
    logic [CFG_H_W-1:0] res;
    if (v < CFG_H_W'(3)) begin
      res = CFG_H_W'(3);
    end else if (v > CFG_H_W'(MAX_HEIGHT)) begin
      res = CFG_H_W'(MAX_HEIGHT);
    end else begin
      res = v;
    end
    return res;
  endfunction

  // 5*center minus the four direct neighbors, clamped to 0..255.
  function automatic logic [7:0] sharpen_chan(logic [7:0] c, logic [7:0] u,
                                              logic [7:0] d, logic [7:0] l,
                                              logic [7:0] r);
    logic signed [11:0] acc;
    logic [7:0]         res;
    acc = $signed({4'b0, c} * 12'd5) - $signed({4'b0, u}) - $signed({4'b0, d})
        - $signed({4'b0, l}) - $signed({4'b0, r});
    if (acc < 0) begin
      res = 8'd0;
    end else if (acc > 12'sd255) begin
      res = 8'd255;
    end else begin
      res = acc[7:0];
    end
    return res;
  endfunction

  function automatic pixel_t sharpen_px(taps_t t, logic inner);
    pixel_t res;
    if (inner) begin
      res.red   = sharpen_chan(t.center.red, t.up.red, t.down.red,
                               t.left.red, t.right.red);
      res.green = sharpen_chan(t.center.green, t.up.green, t.down.green,
                               t.left.green, t.right.green);
      res.blue  = sharpen_chan(t.center.blue, t.up.blue, t.down.blue,
                               t.left.blue, t.right.blue);
    end else begin
      res = t.center;
    end
    return res;
  endfunction

endpackage

@@ hdl/sharpen_3x3_convolution.sv @@
// Top level of the streaming 3x3 sharpen filter.
//
// Pixels enter on the in_ channel in raster order: in_tdata carries red, green
// and blue, in_tuser marks a drain item that stands for a black pixel. Each
// item yields at most one result on the out_ channel, the sharpened pixel one
// row plus one pixel behind the input; out_tlast flags the last pixel of the
// frame. After a frame's last pixel, image_width+1 drain items push out the
// remaining results. Interior pixels become 5*center minus the four direct
// neighbors, clamped to 0..255; border pixels pass through.
//
// Throughput is one item per clock while in_tready is high, bounded by the
// line memory, which takes one read and one write of a column entry per
// cycle. An item passes stage 1, stage 2 and the result queue before its
// result reaches out_tvalid. When the receiver stalls, a four-entry result
// queue absorbs the pipeline and in_tready falls once queue plus in-flight
// items fill it. After reset and after every configuration write, in_tready
// stays low while the frame size and the output position are rebuilt.
// The line memory is not cleared; its entries are written before use.
`include "sharpen_3x3_convolution_defines.svh"
module sharpen_3x3_convolution import sh3_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // in_red, in_green, in_blue
  input  logic                  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata,  // out_red, out_green, out_blue
  output logic                  out_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW1 = ROW_W + 1;

  // configuration
  logic [CFG_W_W-1:0] cfg_width_r, cfg_width_nxt;
  logic [CFG_H_W-1:0] cfg_height_r, cfg_height_nxt;
  logic [CFG_W_W-1:0] w;
  logic [CFG_H_W-1:0] h;

  // frame counters
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CNT_W-1:0]   items_r, items_nxt;
  logic [COL_W-1:0]   ocol_r, ocol_nxt;
  logic [ROW_W-1:0]   orow_r, orow_nxt;
  logic [COL_W-1:0]   c;
  logic [COL_W:0]     c_inc;
  logic [CNT_W-1:0]   items_inc;
  logic [COL_W:0]     ocol_inc;
  logic [ROW_W:0]     orow_inc;
  logic               acc, has, last, inner;
  pixel_t             px_in;

  // position sequencer
  logic               busy;
  logic [CNT_W-1:0]   thr;
  pos_load_t          pos;

  // stage 1: line memory read data
  logic               s1_valid_r, s1_has_r, s1_last_r, s1_inner_r, s1_fwd_r;
  logic [COL_W-1:0]   s1_addr_r;
  pixel_t             s1_px_r;
  line_word_t         s1_fwd_word_r;
  logic [LINE_W-1:0]  ram_q;
  line_word_t         rd_word, wr_word;

  // window taps kept from earlier columns
  pixel_t             top_d1_r, mid_d1_r, mid_d2_r, px_d1_r;
  taps_t              taps;

  // stage 2: taps ready for the sharpen arithmetic
  logic               s2_valid_r, s2_last_r, s2_inner_r;
  taps_t              s2_taps_r;

  // result queue
  result_t            fifo_din, fifo_dout;
  logic [OCNT_W-1:0]  fifo_count;
  logic [OCNT_W-1:0]  occ;

  assign w = clamp_width(cfg_width_r);
  assign h = clamp_height(cfg_height_r);

  // Hold input while the sequencer runs or the queue could overflow.
  assign occ       = fifo_count + OCNT_W'(s1_valid_r) + OCNT_W'(s2_valid_r);
  assign in_tready = !busy && (occ < OCNT_W'(OUT_DEPTH));
  assign acc       = in_tvalid && in_tready;

  // A drain item is a black pixel.
  assign px_in = in_tuser ? '0 : pixel_t'(in_tdata);

  // Restart the column at zero if a smaller width left it out of range.
  assign c         = ({1'b0, col_r} >= w) ? '0 : col_r;
  assign c_inc     = {1'b0, c} + 1'b1;
  assign items_inc = items_r + 1'b1;
  assign ocol_inc  = {1'b0, ocol_r} + 1'b1;
  assign orow_inc  = {1'b0, orow_r} + 1'b1;

  // Results start once the window has reached the first pixel.
  assign has   = items_r > CNT_W'(w);
  assign last  = has && (items_inc >= thr);
  assign inner = (orow_r != '0) && (orow_inc < RW1'(h))
              && (ocol_r != '0) && (ocol_inc < w);

  always_comb begin
    cfg_width_nxt  = cfg_width_r;
    cfg_height_nxt = cfg_height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_width_nxt  = cfg_wdata[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_nxt = cfg_wdata[CFG_H_W-1:0];
      endcase
    end
  end

  always_comb begin
    col_nxt   = col_r;
    items_nxt = items_r;
    ocol_nxt  = ocol_r;
    orow_nxt  = orow_r;
    if (acc) begin
      items_nxt = last ? '0 : items_inc;
      if (last || (c_inc >= w)) begin
        col_nxt = '0;
      end else begin
        col_nxt = c_inc[COL_W-1:0];
      end
    end
    if (pos.load) begin
      ocol_nxt = pos.ocol;
      orow_nxt = pos.orow;
    end else if (acc && has) begin
      // Advance the output position; drop back to the origin at frame end.
      if (last) begin
        ocol_nxt = '0;
        orow_nxt = '0;
      end else if (ocol_inc >= w) begin
        ocol_nxt = '0;
        orow_nxt = orow_inc[ROW_W-1:0];
      end else begin
        ocol_nxt = ocol_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= WIDTH_RESET;
      cfg_height_r <= HEIGHT_RESET;
      col_r        <= '0;
      items_r      <= '0;
      ocol_r       <= '0;
      orow_r       <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      top_d1_r     <= '0;
      mid_d1_r     <= '0;
      mid_d2_r     <= '0;
      px_d1_r      <= '0;
    end else begin
      cfg_width_r  <= cfg_width_nxt;
      cfg_height_r <= cfg_height_nxt;
      col_r        <= col_nxt;
      items_r      <= items_nxt;
      ocol_r       <= ocol_nxt;
      orow_r       <= orow_nxt;
      s1_valid_r   <= acc;
      s2_valid_r   <= s1_valid_r && s1_has_r;
      if (s1_valid_r) begin
        // shift the window one column
        top_d1_r <= rd_word.upper;
        mid_d2_r <= mid_d1_r;
        mid_d1_r <= rd_word.middle;
        px_d1_r  <= s1_px_r;
      end
    end
  end

  sh3_pos_div u_pos_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cfg_we),
    .width      (w),
    .height     (h),
    .items_seen (items_r),
    .busy       (busy),
    .thr        (thr),
    .pos        (pos)
  );

  // Both lines share one entry per column: read at accept, write back in
  // stage 1 with the middle line moved up and the new pixel below it.
  sh3_line_ram #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W),
    .DATA_W (LINE_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (wr_word),
    .raddr (c),
    .rdata (ram_q)
  );

  // The write of stage 1 lands at the same edge as the next read; forward it
  // when both hit one column (first item of a frame after the last one).
  assign rd_word        = s1_fwd_r ? s1_fwd_word_r : line_word_t'(ram_q);
  assign wr_word.upper  = rd_word.middle;
  assign wr_word.middle = s1_px_r;

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr_r     <= c;
      s1_px_r       <= px_in;
      s1_has_r      <= has;
      s1_last_r     <= last;
      s1_inner_r    <= inner;
      s1_fwd_r      <= s1_valid_r && (c == s1_addr_r);
      s1_fwd_word_r <= wr_word;
    end
  end

  assign taps.center = mid_d1_r;
  assign taps.up     = top_d1_r;
  assign taps.down   = px_d1_r;
  assign taps.left   = mid_d2_r;
  assign taps.right  = rd_word.middle;

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_taps_r  <= taps;
      s2_last_r  <= s1_last_r;
      s2_inner_r <= s1_inner_r;
    end
  end

  assign fifo_din.px        = sharpen_px(s2_taps_r, s2_inner_r);
  assign fifo_din.frame_end = s2_last_r;

  sh3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .din       (fifo_din),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .dout      (fifo_dout),
    .count     (fifo_count)
  );

  assign out_tdata = fifo_dout.px;
  assign out_tlast = fifo_dout.frame_end;

  `SH3_ASSERT_IMPLIES(a_pos_in_range, !busy, ocol_r < w)
  `SH3_ASSERT_IMPLIES(a_result_queued, acc && has, ##2 s2_valid_r)
  `SH3_ASSERT_NEXT(a_frame_restart, acc && last, items_r == '0 && col_r == '0)

endmodule

@@ hdl/sh3_line_ram.sv @@
// Simple dual-port line memory with registered read data.
module sh3_line_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/sh3_pos_div.sv @@
// Sequencer that rebuilds frame size and output position after a register write.
module sh3_pos_div import sh3_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [CFG_W_W-1:0] width,
  input  logic [CFG_H_W-1:0] height,
  input  logic [CNT_W-1:0]   items_seen,
  output logic               busy,
  output logic [CNT_W-1:0]   thr,
  output pos_load_t          pos
);

  seq_state_t                  state_r, state_nxt;
  logic [STEP_W-1:0]           step_r, step_nxt;
  logic [CNT_W-1:0]            total_r, total_nxt;
  logic [CNT_W-1:0]            thr_r, thr_nxt;
  logic [CNT_W-1:0]            num_r, num_nxt;
  logic [COL_W-1:0]            rem_r, rem_nxt;
  logic [COL_W:0]              trial;
  logic                        ge;
  logic [CFG_W_W+CFG_H_W-1:0]  prod;
  logic [CNT_W-1:0]            w_ext;
  logic [CNT_W-1:0]            dividend;

  assign prod     = width * height;
  assign w_ext    = CNT_W'(width);
  // position of the next result: items_seen - width - 1, or zero in warm-up
  assign dividend = (items_seen > w_ext) ? items_seen - w_ext - 1'b1 : '0;
  assign trial    = {rem_r, num_r[CNT_W-1]};
  assign ge       = trial >= width;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_MUL;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
    thr_r   <= thr_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    total_nxt = total_r;
    thr_nxt   = thr_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    unique case (state_r)
      SEQ_IDLE: ;
      SEQ_MUL: begin
        total_nxt = prod[CNT_W-1:0];
        num_nxt   = dividend;
        state_nxt = SEQ_THR;
      end
      SEQ_THR: begin
        thr_nxt   = total_r + w_ext + 1'b1;
        rem_nxt   = '0;
        step_nxt  = '0;
        state_nxt = SEQ_DIV;
      end
      SEQ_DIV: begin
        // restoring division, one quotient bit per cycle
        rem_nxt  = ge ? COL_W'(trial - width) : trial[COL_W-1:0];
        num_nxt  = {num_r[CNT_W-2:0], ge};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(CNT_W - 1)) begin
          state_nxt = SEQ_LOAD;
        end
      end
      SEQ_LOAD: state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
    if (start) begin
      state_nxt = SEQ_MUL;
    end
  end

  assign busy     = state_r != SEQ_IDLE;
  assign thr      = thr_r;
  assign pos.load = state_r == SEQ_LOAD;
  assign pos.ocol = rem_r;
  assign pos.orow = num_r[ROW_W-1:0];

endmodule

@@ hdl/sh3_out_fifo.sv @@
// Small result queue that decouples the filter pipeline from the receiver.
`include "sharpen_3x3_convolution_defines.svh"
module sh3_out_fifo import sh3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  result_t           din,
  input  logic              out_ready,
  output logic              out_valid,
  output result_t           dout,
  output logic [OCNT_W-1:0] count
);

  result_t            mem_r [OUT_DEPTH];
  logic [OPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [OCNT_W-1:0]  count_r, count_nxt;
  logic               pop;

  assign out_valid = count_r != '0;
  assign pop       = out_valid && out_ready;
  assign dout      = mem_r[rd_ptr_r];
  assign count     = count_r;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  `SH3_ASSERT_IMPLIES(a_fifo_no_overflow, push && !pop, count_r < OCNT_W'(OUT_DEPTH))

endmodule

@@ test/sharpen_3x3_convolution_tb.sv @@
// Self-checking testbench for the streaming 3x3 sharpen filter.
`timescale 1ns / 100ps

module sharpen_3x3_convolution_tb import sh3_pkg::*; ();

  localparam int unsigned RANDOM_ITEMS  = 1650;
  localparam int unsigned SETTLE_CYCLES = 8;        // result path plus output queue
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  // One predicted result: the sharpened pixel and its end-of-frame flag.
  typedef struct {
    pixel_t px;
    bit     last;
  } sharp_px_t;

  // Tracks the filter: line stores, window, position and frame size, and
  // keeps the sharpened pixels still owed by the block in arrival order.
  class sharpen_tracker;
    pixel_t      row_above[MAX_WIDTH];
    pixel_t      row_mid[MAX_WIDTH];
    pixel_t      win[9];
    int unsigned col, seen, width_reg, height_reg;
    sharp_px_t   owed[$];
    int unsigned errors, results, frames, items, blacks;

    function new();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i] = '0;
        row_mid[i]   = '0;
      end
      for (int i = 0; i < 9; i++) win[i] = '0;
      col = 0;
      seen = 0;
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      errors = 0;
      results = 0;
      frames = 0;
      items = 0;
      blacks = 0;
    endfunction

    function int unsigned bound_size(int unsigned v, int unsigned top);
      if (v < 3) return 3;
      if (v > top) return top;
      return v;
    endfunction

    function int unsigned eff_width();
      return bound_size(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned eff_height();
      return bound_size(height_reg, MAX_HEIGHT);
    endfunction

    // Items that carry one whole frame through: the pixels plus the drain tail.
    function int unsigned frame_len();
      return eff_width() * eff_height() + eff_width() + 1;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg  = data[CFG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_reg = data[CFG_H_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [7:0] boost(bit [7:0] c, bit [7:0] u, bit [7:0] d, bit [7:0] l,
                             bit [7:0] r);
      int acc;
      acc = 5 * int'(c) - int'(u) - int'(d) - int'(l) - int'(r);
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return acc[7:0];
    endfunction

    function void take_pixel(bit drain, pixel_t px_in);
      int unsigned w, h, c, p, orow, ocol;
      pixel_t      px, top, mid;
      bit          inner;
      sharp_px_t   res;
      w = eff_width();
      h = eff_height();
      px = drain ? pixel_t'(0) : px_in;
      items++;
      // Shift the line stores down one row at this column.
      c = (col >= w) ? 0 : col;
      top = row_above[c];
      mid = row_mid[c];
      row_above[c] = mid;
      row_mid[c]   = px;
      // Slide the window one column left and load the new column.
      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      col = (c + 1 >= w) ? 0 : c + 1;
      seen++;
      // Warm-up: the window has not reached the first pixel yet.
      if (seen < w + 2) return;
      p = seen - w - 2;
      orow = p / w;
      ocol = p % w;
      inner = orow >= 1 && orow + 1 < h && ocol >= 1 && ocol + 1 < w;
      if (inner) begin
        res.px.red   = boost(win[4].red, win[1].red, win[7].red, win[3].red, win[5].red);
        res.px.green = boost(win[4].green, win[1].green, win[7].green, win[3].green,
                             win[5].green);
        res.px.blue  = boost(win[4].blue, win[1].blue, win[7].blue, win[3].blue,
                             win[5].blue);
      end else begin
        res.px = win[4];
      end
      res.last = (p >= w * h - 1);
      if (res.last) begin
        seen = 0;
        col = 0;
      end
      owed.insert(owed.size(), res);
    endfunction

    function void match_output(pixel_t px, bit last);
      sharp_px_t want;
      if (owed.size() == 0) begin
        $error("unexpected result: red %0d green %0d blue %0d frame_end %0d",
               px.red, px.green, px.blue, last);
        errors++;
        return;
      end
      want = owed.pop_front();
      results++;
      if (last) frames++;
      if (px.red !== want.px.red) begin
        $error("out_red mismatch: expected %0d, got %0d", want.px.red, px.red);
        errors++;
      end
      if (px.green !== want.px.green) begin
        $error("out_green mismatch: expected %0d, got %0d", want.px.green, px.green);
        errors++;
      end
      if (px.blue !== want.px.blue) begin
        $error("out_blue mismatch: expected %0d, got %0d", want.px.blue, px.blue);
        errors++;
      end
      if (last !== want.last) begin
        $error("frame_end mismatch: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;     // in_red, in_green, in_blue
  logic                  in_tuser = 1'b0;   // action
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;         // out_red, out_green, out_blue
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sharpen_tracker track;
  bit             src_idle  = 1'b1;   // sender inserts gaps between items
  bit             sink_idle = 1'b1;   // receiver stalls between results

  sharpen_3x3_convolution u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels at every edge. Note the accepted item before checking
  // the result so the owed queue always holds the prediction in time.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) track.take_pixel(in_tuser, in_tdata);
      if (out_tvalid && out_tready) track.match_output(out_tdata, out_tlast);
    end
  end

  // Receiver: stall for a random gap before each result while idling is on;
  // otherwise hold tready high so results stream back to back.
  initial begin : result_sink
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = sink_idle ? $urandom_range(9, 0) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  function automatic pixel_t rgb(bit [7:0] r, bit [7:0] g, bit [7:0] b);
    pixel_t res;
    res.red   = r;
    res.green = g;
    res.blue  = b;
    return res;
  endfunction

  // Mix of rail values, values near a frame-wide base and plain noise, so that
  // both clamps and unclamped interior results show up.
  function automatic bit [7:0] pick_chan(int base);
    int v;
    case ($urandom_range(9, 0))
      0: v = 0;
      1: v = 255;
      2, 3, 4, 5: v = base + $urandom_range(40, 0) - 20;
      default: v = $urandom_range(255, 0);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Offer one item and hold it until the block takes it. Valid stays high
  // afterwards; the caller drops it when the stream pauses.
  task automatic send_item(bit drain, pixel_t px);
    int unsigned gap;
    gap = src_idle ? $urandom_range(9, 0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= drain;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait for every owed result, then let the pipeline settle so
  // the block is idle for a register write.
  task automatic drain_out();
    in_tvalid <= 1'b0;
    while (track.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] hd);
    cfg_we    <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_wdata <= wd;
    track.write_reg(REG_IMAGE_WIDTH, wd);
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_wdata <= hd;
    track.write_reg(REG_IMAGE_HEIGHT, hd);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Feed one whole frame at the current size: pixels with a few black drain
  // items inside, then the drain tail, some of it replaced by stray pixels.
  task automatic run_frame(output int unsigned sent);
    int unsigned area, len, black_pct, noise_pct, base;
    bit          drain;
    area = track.eff_width() * track.eff_height();
    len  = track.frame_len();
    black_pct = $urandom_range(10, 0);
    noise_pct = $urandom_range(20, 0);
    base = $urandom_range(255, 0);
    src_idle  = ($urandom_range(3, 0) != 0);
    sink_idle = ($urandom_range(3, 0) != 0);
    for (int unsigned i = 0; i < len; i++) begin
      if (i < area) begin
        drain = ($urandom_range(99, 0) < black_pct);
        if (drain) track.blacks++;
      end else begin
        drain = !($urandom_range(99, 0) < noise_pct);
      end
      send_item(drain, rgb(pick_chan(base), pick_chan(base), pick_chan(base)));
    end
    sent = len;
  endtask

  initial begin : stimulus
    int unsigned n_rand, sent, w, h;
    track = new();
    n_rand = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Width below range (only the top data bits set) and height below range:
    // both saturate to 3. Center sharpens to a red high clamp, a green low
    // clamp and an unclamped blue; corners carry the channel extremes.
    set_regs(13'h1800, 13'h0001);
    send_item(1'b0, rgb(8'd0,   8'd0,   8'd0));
    send_item(1'b0, rgb(8'd0,   8'd255, 8'd80));
    send_item(1'b0, rgb(8'd255, 8'd255, 8'd255));
    send_item(1'b0, rgb(8'd0,   8'd255, 8'd80));
    send_item(1'b0, rgb(8'd255, 8'd0,   8'd100));
    send_item(1'b0, rgb(8'd0,   8'd255, 8'd80));
    send_item(1'b0, rgb(8'd255, 8'd255, 8'd255));
    send_item(1'b0, rgb(8'd0,   8'd255, 8'd80));
    send_item(1'b0, rgb(8'd0,   8'd0,   8'd0));
    repeat (4) send_item(1'b1, rgb(8'd255, 8'd255, 8'd255));

    // Next frame straight after, same size: black drain items inside the
    // frame, one of them at the center, and a stray pixel in the tail.
    send_item(1'b0, rgb(8'd10,  8'd20,  8'd30));
    send_item(1'b0, rgb(8'd200, 8'd100, 8'd50));
    send_item(1'b0, rgb(8'd255, 8'd0,   8'd255));
    send_item(1'b0, rgb(8'd1,   8'd2,   8'd3));
    send_item(1'b1, rgb(8'hA5,  8'hA5,  8'hA5));
    send_item(1'b0, rgb(8'd254, 8'd253, 8'd252));
    send_item(1'b0, rgb(8'd0,   8'd255, 8'd0));
    send_item(1'b1, rgb(8'd0,   8'd0,   8'd0));
    send_item(1'b0, rgb(8'd128, 8'd128, 8'd128));
    send_item(1'b1, rgb(8'd0,   8'd0,   8'd0));
    send_item(1'b0, rgb(8'd77,  8'd177, 8'd7));
    repeat (2) send_item(1'b1, rgb(8'd0, 8'd0, 8'd0));
    drain_out();

    // Random frames of small sizes, some back to back at the same size,
    // some after a fresh size that may fall below the lower bound.
    while (n_rand < RANDOM_ITEMS) begin
      if (n_rand == 0 || $urandom_range(1, 0) == 1) begin
        drain_out();
        w = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(12, 3);
        h = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(10, 3);
        set_regs({2'($urandom_range(3, 0)), 11'(w)}, 13'(h));
      end
      run_frame(sent);
      n_rand += sent;
    end
    drain_out();

    $display("Run covered %0d items in %0d frames, %0d sharpened pixels checked,",
             track.items, track.frames, track.results);
    $display("  sizes 3x3 up to 12x10 incl. small register values, %0d black pixels in frames.",
             track.blacks);
    if (track.errors == 0 && track.owed.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
